// File: hw/rtl/tsrc_pkg.sv
// Shared types, codes and defaults for the terrain sample recency cache.
package tsrc_pkg;

  localparam int unsigned DefCacheEntries = 256;
  localparam int          DefInvalidHeight = -1000;

  localparam int unsigned KeyW = 34;
  localparam int unsigned RegAddrW = 4;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_SERVICE = 2'd2;

  localparam logic [2:0] KIND_HIT     = 3'd0;
  localparam logic [2:0] KIND_MISS    = 3'd1;
  localparam logic [2:0] KIND_FILLED  = 3'd2;
  localparam logic [2:0] KIND_INVALID = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;

  localparam logic [1:0] REG_MAP_READY = 2'd0;
  localparam logic [1:0] REG_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;
  localparam logic [1:0] REG_HEADER    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        column;
    logic [15:0]        row;
    logic signed [15:0] fill_value;
    logic               fill_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic signed [15:0] height;
    logic [KeyW-1:0]    fetch_address;
    logic [31:0]        hit_total;
    logic [31:0]        miss_total;
  } out_item_t;

  typedef struct packed {
    logic        map_ready;
    logic [15:0] grid_columns;
    logic [15:0] grid_rows;
    logic [9:0]  header_bytes;
  } cfg_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [31:0]     recency;
    logic [15:0]     height;
  } entry_t;

  typedef struct packed {
    logic load;
    logic set_invalid;
    logic set_ignore;
    logic calc_prod;
    logic calc_key;
    logic scan_clr;
    logic scan_rd;
    logic scan_inc;
    logic hit_wr;
    logic miss;
    logic fill;
    logic service;
    logic sort_init;
    logic sort_rd_i;
    logic sort_ld_cur;
    logic sort_rd_prev;
    logic sort_shift;
    logic sort_put;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       pos_ok;
    logic       match;
    logic       idx_last;
    logic       pend;
    logic       miss_nz;
    logic       i_last;
    logic       ahead;
    logic       pos_one;
    logic       out_busy;
  } status_t;

endpackage

// File: hw/rtl/tsrc_regs.sv
// APB configuration registers of the terrain sample recency cache.
module tsrc_regs
  import tsrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MAP_READY: cfg_q.map_ready    <= pwdata[0];
        REG_COLUMNS:   cfg_q.grid_columns <= pwdata[15:0];
        REG_ROWS:      cfg_q.grid_rows    <= pwdata[15:0];
        REG_HEADER:    cfg_q.header_bytes <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAP_READY: prdata = {31'd0, cfg_q.map_ready};
      REG_COLUMNS:   prdata = {16'd0, cfg_q.grid_columns};
      REG_ROWS:      prdata = {16'd0, cfg_q.grid_rows};
      REG_HEADER:    prdata = {22'd0, cfg_q.header_bytes};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/tsrc_ctrl.sv
// Sequencing state machine of the terrain sample recency cache.
module tsrc_ctrl
  import tsrc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_KEY,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SORT_RDI,
    S_SORT_LDI,
    S_SORT_RDP,
    S_SORT_CMP,
    S_SORT_PUT,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.opcode)
          OP_LOOKUP: begin
            if (status_i.pos_ok) begin
              cmd_o.calc_prod = 1'b1;
              state_d         = S_KEY;
            end else begin
              cmd_o.set_invalid = 1'b1;
              state_d           = S_DONE;
            end
          end
          OP_FILL: begin
            if (status_i.pend) cmd_o.fill = 1'b1;
            else cmd_o.set_ignore = 1'b1;
            state_d = S_DONE;
          end
          OP_SERVICE: begin
            if (status_i.miss_nz) begin
              cmd_o.sort_init = 1'b1;
              state_d         = S_SORT_RDI;
            end else begin
              cmd_o.service = 1'b1;
              state_d       = S_DONE;
            end
          end
          default: begin
            cmd_o.set_ignore = 1'b1;
            state_d          = S_DONE;
          end
        endcase
      end
      S_KEY: begin
        cmd_o.calc_key = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (status_i.match) begin
          cmd_o.hit_wr = 1'b1;
          state_d      = S_DONE;
        end else if (status_i.idx_last) begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_SORT_RDI: begin
        cmd_o.sort_rd_i = 1'b1;
        state_d         = S_SORT_LDI;
      end
      S_SORT_LDI: begin
        cmd_o.sort_ld_cur = 1'b1;
        state_d           = S_SORT_RDP;
      end
      S_SORT_RDP: begin
        cmd_o.sort_rd_prev = 1'b1;
        state_d            = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (status_i.ahead) begin
          cmd_o.sort_shift = 1'b1;
          state_d = status_i.pos_one ? S_SORT_PUT : S_SORT_RDP;
        end else begin
          state_d = S_SORT_PUT;
        end
      end
      S_SORT_PUT: begin
        cmd_o.sort_put = 1'b1;
        if (status_i.i_last) begin
          cmd_o.service = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_SORT_RDI;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/tsrc_datapath.sv
// Entry memory, search and sort datapath, counters and result register.
module tsrc_datapath
  import tsrc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES  = DefCacheEntries,
  parameter int          INVALID_HEIGHT = DefInvalidHeight
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = $clog2(CACHE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);
  localparam logic [15:0] InvH = 16'(INVALID_HEIGHT);

  entry_t mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_q;

  in_item_t        item_q;
  logic [31:0]     prod_q;
  logic [KeyW-1:0] key_q;
  logic [IdxW-1:0] idx_q, i_q, pos_q, fp_q;
  logic [31:0]     time_q, hit_q, miss_q;
  logic [KeyW-1:0] pend_key_q;
  logic            pend_q;
  entry_t          rd_q, cur_q;
  logic            rdv_q, curv_q;
  logic [2:0]      kind_q;
  logic [15:0]     ht_q;
  logic [KeyW-1:0] addr_q;
  out_item_t       out_q;
  logic            out_valid_q;

  entry_t          rd_m;
  logic            re, we, wv;
  logic [IdxW-1:0] raddr, waddr;
  entry_t          wdata;
  logic [15:0]     fill_h;
  logic            ahead;

  // Invalid entries read as the reset value.
  assign rd_m = rdv_q ? rd_q : '0;

  assign fill_h = !item_q.fill_ok ? InvH :
                  (item_q.fill_value[15] ? 16'd0 : item_q.fill_value);

  always_comb begin
    if (cur_q.recency != rd_m.recency) ahead = cur_q.recency > rd_m.recency;
    else if (curv_q != rdv_q)          ahead = curv_q;
    else                               ahead = cur_q.key > rd_m.key;
  end

  always_comb begin
    re    = cmd_i.scan_rd | cmd_i.sort_rd_i | cmd_i.sort_rd_prev;
    raddr = idx_q;
    if (cmd_i.sort_rd_i)    raddr = i_q;
    if (cmd_i.sort_rd_prev) raddr = pos_q - IdxW'(1);
    we    = 1'b0;
    waddr = pos_q;
    wdata = cur_q;
    wv    = 1'b1;
    if (cmd_i.hit_wr) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = '{key: rd_m.key, recency: time_q, height: rd_m.height};
    end else if (cmd_i.fill) begin
      we    = 1'b1;
      waddr = fp_q;
      wdata = '{key: pend_key_q, recency: time_q, height: fill_h};
    end else if (cmd_i.sort_shift) begin
      we    = 1'b1;
      wdata = rd_m;
      wv    = rdv_q;
    end else if (cmd_i.sort_put) begin
      we = 1'b1;
      wv = curv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load)        item_q <= in_item_i;
    if (cmd_i.calc_prod)   prod_q <= item_q.row * cfg_i.grid_columns;
    if (cmd_i.calc_key) begin
      key_q <= KeyW'(cfg_i.header_bytes) +
               {1'b0, prod_q + 32'(item_q.column), 1'b0};
    end
    if (cmd_i.sort_ld_cur) begin
      cur_q  <= rd_m;
      curv_q <= rdv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rdv_q       <= 1'b0;
      idx_q       <= '0;
      i_q         <= '0;
      pos_q       <= '0;
      fp_q        <= LastIdx;
      time_q      <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      pend_key_q  <= '0;
      pend_q      <= 1'b0;
      kind_q      <= KIND_IGNORED;
      ht_q        <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) valid_q[waddr] <= wv;
      if (re) rdv_q <= valid_q[raddr];
      if (cmd_i.scan_clr) idx_q <= '0;
      if (cmd_i.scan_inc) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.sort_init) i_q <= IdxW'(1);
      if (cmd_i.sort_put && !cmd_i.service) i_q <= i_q + IdxW'(1);
      if (cmd_i.sort_ld_cur) pos_q <= i_q;
      if (cmd_i.sort_shift) pos_q <= pos_q - IdxW'(1);
      if (cmd_i.set_invalid) begin
        kind_q <= KIND_INVALID;
        ht_q   <= InvH;
        addr_q <= '0;
      end
      if (cmd_i.set_ignore) begin
        kind_q <= KIND_IGNORED;
        ht_q   <= '0;
        addr_q <= '0;
      end
      if (cmd_i.hit_wr) begin
        hit_q  <= hit_q + 32'd1;
        kind_q <= KIND_HIT;
        ht_q   <= rd_m.height;
        addr_q <= key_q;
      end
      if (cmd_i.miss) begin
        miss_q     <= miss_q + 32'd1;
        pend_key_q <= key_q;
        pend_q     <= 1'b1;
        kind_q     <= KIND_MISS;
        ht_q       <= '0;
        addr_q     <= key_q;
      end
      if (cmd_i.fill) begin
        if (fp_q != '0) fp_q <= fp_q - IdxW'(1);
        pend_q <= 1'b0;
        kind_q <= KIND_FILLED;
        ht_q   <= fill_h;
        addr_q <= pend_key_q;
      end
      if (cmd_i.service) begin
        if (miss_q != '0) fp_q <= LastIdx;
        hit_q  <= 32'd1;
        miss_q <= '0;
        time_q <= time_q + 32'd1;
        kind_q <= KIND_IGNORED;
        ht_q   <= '0;
        addr_q <= '0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= '{result_kind: kind_q, height: ht_q, fetch_address: addr_q,
                 hit_total: hit_q, miss_total: miss_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o          = '0;
    status_o.opcode   = item_q.opcode;
    status_o.pos_ok   = cfg_i.map_ready && (item_q.row < cfg_i.grid_rows) &&
                        (item_q.column < cfg_i.grid_columns);
    status_o.match    = rdv_q && (rd_q.key == key_q);
    status_o.idx_last = (idx_q == LastIdx);
    status_o.pend     = pend_q;
    status_o.miss_nz  = (miss_q != '0);
    status_o.i_last   = (i_q == LastIdx);
    status_o.ahead    = ahead;
    status_o.pos_one  = (pos_q == IdxW'(1));
    status_o.out_busy = out_valid_q & ~out_ready_i;
  end

endmodule

// File: hw/rtl/terrain_sample_recency_cache.sv
// Top level of the terrain sample recency cache.
// Use: write map_ready, grid_columns, grid_rows and header_bytes over the APB
// port (byte addresses 0, 4, 8, 12) while idle, then send transactions on the
// input channel (valid/ready). Each input transaction yields exactly one
// result transaction on the output channel.
// A lookup computes the byte address through registered product and key steps,
// then scans the entry memory one entry at a time through the registered read
// port, reading and then comparing; a hit stops the scan, a miss ends it at the
// last entry. Fills, invalid positions and ignored items go on to the result.
// A service item with misses pending runs a stable insertion sort through the
// entry memory read and write ports; without misses it only updates counters.
// One item is worked at a time; the next is accepted once the result sits in
// the output register, even while the receiver stalls. A stalled result holds
// the block in its final step until taken.
// Reset empties the cache at once through per-entry valid flops, clears the
// counters and control registers, and needs no clearing pass.
module terrain_sample_recency_cache
  import tsrc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES  = DefCacheEntries,
  parameter int          INVALID_HEIGHT = DefInvalidHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Hold configuration; the user must write it only while no transaction is in flight; the block does not enforce this.
  tsrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequence lookup, fill and service steps.
  tsrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store entries, compare keys, move entries and drive the result.
  tsrc_datapath #(
    .CACHE_ENTRIES  (CACHE_ENTRIES),
    .INVALID_HEIGHT (INVALID_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hw/rtl/tsrc_checker.sv
// Port-level checker for the terrain sample recency cache, with its bind.
module tsrc_checker
  import tsrc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_item_t            in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_item_t           out_item_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [RegAddrW-1:0] paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.result_kind <= KIND_IGNORED)
    else $error("undefined result kind");

  a_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == KIND_INVALID ||
                    out_item_o.result_kind == KIND_IGNORED)
    |-> out_item_o.fetch_address == '0)
    else $error("address on invalid or ignored result");

endmodule

bind terrain_sample_recency_cache tsrc_checker u_tsrc_checker (.*);

// File: sim/terrain_sample_recency_cache_test.sv
// Self-checking testbench for the terrain sample recency cache.
module terrain_sample_recency_cache_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsrc_pkg::*;

  localparam int unsigned NumEntries = DefCacheEntries;
  localparam logic signed [15:0] BadHeight = 16'(DefInvalidHeight);
  // No transaction for this long means the block is hung.
  localparam int unsigned HangLimit = 600000;

  // Predicts the height cache and holds the results still owed by the block.
  class height_cache_scoreboard;
    logic [KeyW-1:0] slot_key [NumEntries];
    logic [31:0]     slot_age [NumEntries];
    logic [15:0]     slot_h   [NumEntries];
    bit              slot_ok  [NumEntries];
    int unsigned     fill_ptr;
    logic [31:0]     now_tick, hits, misses;
    logic [KeyW-1:0] want_key;
    bit              want_pending;
    cfg_t            cfg;
    out_item_t       owed [$];
    int unsigned     errors;

    function new();
      for (int i = 0; i < NumEntries; i++) begin
        slot_key[i] = '0; slot_age[i] = '0; slot_h[i] = '0; slot_ok[i] = 0;
      end
      fill_ptr = NumEntries - 1;
      now_tick = '0; hits = '0; misses = '0;
      want_key = '0; want_pending = 0;
      cfg = '0;
      errors = 0;
    endfunction

    function bit goes_first(int a, int b);
      if (slot_age[a] != slot_age[b]) return slot_age[a] > slot_age[b];
      if (slot_ok[a] != slot_ok[b]) return slot_ok[a];
      return slot_key[a] > slot_key[b];
    endfunction

    // Stable insertion sort by recency, validity and key, all descending.
    function void order_by_recency();
      logic [KeyW-1:0] k;
      logic [31:0] g;
      logic [15:0] h;
      bit v;
      int j;
      for (int i = 1; i < NumEntries; i++) begin
        j = i - 1;
        while (j >= 0 && goes_first(i, j)) j--;
        k = slot_key[i]; g = slot_age[i]; h = slot_h[i]; v = slot_ok[i];
        for (int m = i; m > j + 1; m--) begin
          slot_key[m] = slot_key[m-1]; slot_age[m] = slot_age[m-1];
          slot_h[m] = slot_h[m-1]; slot_ok[m] = slot_ok[m-1];
        end
        slot_key[j+1] = k; slot_age[j+1] = g; slot_h[j+1] = h; slot_ok[j+1] = v;
      end
    endfunction

    // Note an accepted input and queue its expected result.
    function void note_request(in_item_t req);
      out_item_t r;
      logic [KeyW-1:0] addr;
      int found;
      r = '0;
      r.result_kind = KIND_IGNORED;
      case (req.opcode)
        OP_LOOKUP: begin
          if (!cfg.map_ready || req.row >= cfg.grid_rows ||
              req.column >= cfg.grid_columns) begin
            r.result_kind = KIND_INVALID;
            r.height = BadHeight;
          end else begin
            addr = KeyW'(cfg.header_bytes) + 2 * (KeyW'(req.row) * cfg.grid_columns
                   + KeyW'(req.column));
            found = -1;
            for (int i = 0; i < NumEntries; i++)
              if (found < 0 && slot_ok[i] && slot_key[i] == addr) found = i;
            r.fetch_address = addr;
            if (found >= 0) begin
              slot_age[found] = now_tick;
              hits++;
              r.result_kind = KIND_HIT;
              r.height = slot_h[found];
            end else begin
              misses++;
              want_key = addr;
              want_pending = 1;
              r.result_kind = KIND_MISS;
            end
          end
        end
        OP_FILL: begin
          if (want_pending) begin
            if (!req.fill_ok) r.height = BadHeight;
            else if (req.fill_value < 0) r.height = '0;
            else r.height = req.fill_value;
            slot_key[fill_ptr] = want_key; slot_ok[fill_ptr] = 1;
            slot_age[fill_ptr] = now_tick; slot_h[fill_ptr] = r.height;
            if (fill_ptr > 0) fill_ptr--;
            want_pending = 0;
            r.result_kind = KIND_FILLED;
            r.fetch_address = want_key;
          end
        end
        OP_SERVICE: begin
          if (misses != 0) begin
            order_by_recency();
            fill_ptr = NumEntries - 1;
          end
          hits = 1;
          misses = 0;
          now_tick++;
        end
        default: ;
      endcase
      r.hit_total = hits;
      r.miss_total = misses;
      owed.push_back(r);
    endfunction

    // Compare one result against the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.result_kind !== exp.result_kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, exp.result_kind,
                 got.result_kind);
        errors++;
      end
      if (got.height !== exp.height) begin
        $display("%0t: height expected %0d actual %0d", $time, exp.height, got.height);
        errors++;
      end
      if (got.fetch_address !== exp.fetch_address) begin
        $display("%0t: fetch_address expected %h actual %h", $time, exp.fetch_address,
                 got.fetch_address);
        errors++;
      end
      if (got.hit_total !== exp.hit_total) begin
        $display("%0t: hit_total expected %0d actual %0d", $time, exp.hit_total,
                 got.hit_total);
        errors++;
      end
      if (got.miss_total !== exp.miss_total) begin
        $display("%0t: miss_total expected %0d actual %0d", $time, exp.miss_total,
                 got.miss_total);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [RegAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  height_cache_scoreboard cache_sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned take_stall_pct = 0;
  bit hold_off = 0;
  int unsigned quiet_cycles = 0;
  // Recent miss addresses, replayed as lookups to get hits.
  logic [15:0] seen_col [$];
  logic [15:0] seen_row [$];

  terrain_sample_recency_cache DUT (.*);

  always #4 clk_i = ~clk_i;

  // Take results with random stalls; a long hold-off comes from the stimulus.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) cache_sb.check_result(out_item_o);
      out_ready_i <= !hold_off && ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HangLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one transaction; note it in the scoreboard when accepted.
  task automatic send_item(in_item_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    cache_sb.note_request(req);
    in_valid_i <= 1'b0;
    // The block is busy for at least this cycle; advance before the next drive.
    @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [15:0] c, logic [15:0] r,
                                         logic [15:0] v, logic ok);
    in_item_t it;
    it.opcode = op; it.column = c; it.row = r; it.fill_value = v; it.fill_ok = ok;
    return it;
  endfunction

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegAddrW'({idx, 2'b00}); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MAP_READY: cache_sb.cfg.map_ready = value[0];
      REG_COLUMNS:   cache_sb.cfg.grid_columns = value[15:0];
      REG_ROWS:      cache_sb.cfg.grid_rows = value[15:0];
      default:       cache_sb.cfg.header_bytes = value[9:0];
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain all results, then idle before reconfiguring.
  task automatic drain();
    while (cache_sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_grid(logic ready, logic [15:0] cols, logic [15:0] rows,
                          logic [9:0] hdr);
    drain();
    write_reg(REG_MAP_READY, 32'(ready) | 32'hFFFF_FFFE);
    write_reg(REG_COLUMNS, {16'hA5A5, cols});
    write_reg(REG_ROWS, {16'h5A5A, rows});
    write_reg(REG_HEADER, {22'h3FFFFF, hdr});
  endtask

  // Mostly lookup-fill pairs inside the grid, with replays, services and noise.
  task automatic random_burst(int unsigned count);
    in_item_t it;
    int unsigned pick, k;
    logic [15:0] c, r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (seen_col.size() != 0 && $urandom_range(2) == 0) begin
          k = $urandom_range(seen_col.size() - 1);
          c = seen_col[k]; r = seen_row[k];
        end else begin
          c = (cache_sb.cfg.grid_columns == 0) ? 16'(0) :
              16'($urandom_range(cache_sb.cfg.grid_columns - 1));
          r = (cache_sb.cfg.grid_rows == 0) ? 16'(0) :
              16'($urandom_range(cache_sb.cfg.grid_rows - 1));
          if ($urandom_range(9) == 0) c = 16'($urandom);
          if ($urandom_range(9) == 0) r = 16'($urandom);
        end
        send_item(make_item(OP_LOOKUP, c, r, 16'($urandom), 1'($urandom)));
        if (cache_sb.want_pending && $urandom_range(9) != 0) begin
          seen_col.push_back(c); seen_row.push_back(r);
          if (seen_col.size() > 40) begin
            void'(seen_col.pop_front()); void'(seen_row.pop_front());
          end
          send_item(make_item(OP_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom_range(7) != 0));
          n++;
        end
      end else if (pick < 70) begin
        send_item(make_item(OP_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom)));
      end else if (pick < 77) begin
        send_item(make_item(OP_SERVICE, 16'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom)));
      end else begin
        send_item(make_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                            16'($urandom), 1'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: map not ready, then extremes and every opcode.
    send_item(make_item(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_FILL, 16'd0, 16'd0, 16'h1234, 1'b1));
    send_item(make_item(OP_SERVICE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(make_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    set_grid(1'b1, 16'hFFFF, 16'hFFFF, 10'h3FF);
    send_item(make_item(OP_LOOKUP, 16'hFFFE, 16'hFFFE, 16'd0, 1'b0));
    send_item(make_item(OP_FILL, 16'd0, 16'd0, 16'h7FFF, 1'b1));
    send_item(make_item(OP_LOOKUP, 16'hFFFE, 16'hFFFE, 16'd0, 1'b0));
    send_item(make_item(OP_LOOKUP, 16'hFFFF, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_LOOKUP, 16'd0, 16'hFFFF, 16'd0, 1'b0));
    send_item(make_item(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 1'b0));
    // Second miss replaces the pending one; fill with negative value clamps.
    send_item(make_item(OP_LOOKUP, 16'd1, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_FILL, 16'd0, 16'd0, 16'h8000, 1'b1));
    send_item(make_item(OP_LOOKUP, 16'd2, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_FILL, 16'd0, 16'd0, 16'h0100, 1'b0));
    send_item(make_item(OP_LOOKUP, 16'd2, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_SERVICE, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_SERVICE, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_LOOKUP, 16'd1, 16'd0, 16'd0, 1'b0));
    // Duplicate key: header 2 and column 0 alias header 0 and column 1.
    set_grid(1'b1, 16'd4, 16'd4, 10'd2);
    send_item(make_item(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(OP_FILL, 16'd0, 16'd0, 16'd77, 1'b1));
    send_item(make_item(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 1'b0));

    // Random phases across grid settings and idling mixes.
    set_grid(1'b1, 16'd12, 16'd9, 10'd0);
    random_burst(300);
    send_idle_pct = 47;
    random_burst(250);
    set_grid(1'b1, 16'd300, 16'd200, 10'd517);
    send_idle_pct = 0; take_stall_pct = 47;
    random_burst(250);
    send_idle_pct = 17; take_stall_pct = 17;
    random_burst(250);
    set_grid(1'b0, 16'd8, 16'd8, 10'd3);
    random_burst(40);
    set_grid(1'b1, 16'd1, 16'd1, 10'd1023);
    send_idle_pct = 0; take_stall_pct = 0;
    random_burst(60);
    set_grid(1'b1, 16'd20, 16'd20, 10'd64);
    // Long receiver hold-off while items keep coming, to back up the input.
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      random_burst(40);
    join
    random_burst(500);

    while (cache_sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (cache_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
